FILE: src/bitmap_range_mark_erase_unit_defines.svh
// ----------------------------------------------------------------------------
// Bitmap range mark/erase unit: assertion macros
// Shared macros for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANGE_MARK_ERASE_UNIT_DEFINES_SVH
`define BITMAP_RANGE_MARK_ERASE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRME_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRME_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/brme_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap range mark/erase package
// Shared constants, codes and the decoded range type.
// ----------------------------------------------------------------------------
package brme_pkg;

  localparam int TABLE_WORDS_DEFAULT = 1024;
  localparam int SLOT_ORDER_DEFAULT  = 4;
  localparam int WORD_ORDER_DEFAULT  = 5;

  // Widest word index and bit index the parameter ranges allow.
  localparam int MAX_WORD_BITS = 16;
  localparam int MAX_BIT_BITS  = 6;

  localparam logic KIND_MARK  = 1'b0;
  localparam logic KIND_ERASE = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic                     err;
    logic [MAX_WORD_BITS-1:0] first_word;
    logic [MAX_WORD_BITS-1:0] last_word;
    logic [MAX_BIT_BITS-1:0]  first_bit;
    logic [MAX_BIT_BITS-1:0]  last_bit;
  } brme_range_t;

endpackage

FILE: src/brme_ram.sv
// ----------------------------------------------------------------------------
// Bitmap memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brme_ram #(
  parameter int DEPTH = brme_pkg::TABLE_WORDS_DEFAULT,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/brme_decode.sv
// ----------------------------------------------------------------------------
// Request decoder
// Two-stage check of alignment, base and size, and split of the range into
// first and last word and bit positions.
// ----------------------------------------------------------------------------
module brme_decode #(
  parameter int TABLE_WORDS = brme_pkg::TABLE_WORDS_DEFAULT,
  parameter int SLOT_ORDER  = brme_pkg::SLOT_ORDER_DEFAULT,
  parameter int WORD_ORDER  = brme_pkg::WORD_ORDER_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [31:0]          start_address,
  input  logic [31:0]          byte_size,
  input  logic [31:0]          base_address,
  output logic                 done,
  output brme_pkg::brme_range_t range
);

  localparam int AW          = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int WBITS       = 1 << WORD_ORDER;
  localparam int TOTAL_SLOTS = TABLE_WORDS * WBITS;

  logic        a_vld_r;
  logic        b_vld_r;
  logic        mis_r;
  logic        below_r;
  logic        zero_r;
  logic [31:0] off_r;
  logic [31:0] size_m1_r;
  logic [32:0] diff;

  logic [32:0] last_off;
  logic [32:0] last_slot;
  logic [31:0] first_slot;
  logic        over;

  brme_pkg::brme_range_t range_nxt;
  brme_pkg::brme_range_t range_r;

  assign diff = {1'b0, start_address} - {1'b0, base_address};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= go;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      mis_r     <= |start_address[SLOT_ORDER-1:0];
      below_r   <= diff[32];
      off_r     <= diff[31:0];
      zero_r    <= (byte_size == 32'd0);
      size_m1_r <= byte_size - 32'd1;
    end
    if (a_vld_r) begin
      range_r <= range_nxt;
    end
  end

  always_comb begin
    last_off   = {1'b0, off_r} + {1'b0, size_m1_r};
    last_slot  = last_off >> SLOT_ORDER;
    first_slot = off_r >> SLOT_ORDER;
    over       = (last_slot >= 33'(TOTAL_SLOTS));

    range_nxt.err        = mis_r | below_r | zero_r | over;
    range_nxt.first_word = brme_pkg::MAX_WORD_BITS'(first_slot[WORD_ORDER +: AW]);
    range_nxt.last_word  = brme_pkg::MAX_WORD_BITS'(last_slot[WORD_ORDER +: AW]);
    range_nxt.first_bit  = brme_pkg::MAX_BIT_BITS'(first_slot[WORD_ORDER-1:0]);
    range_nxt.last_bit   = brme_pkg::MAX_BIT_BITS'(last_slot[WORD_ORDER-1:0]);
  end

  assign done  = b_vld_r;
  assign range = range_r;

endmodule

FILE: src/bitmap_range_mark_erase_unit.sv
// ----------------------------------------------------------------------------
// Bitmap range mark/erase unit
// Marks or erases a byte range in a slot bitmap held in one memory, checking
// every covered bit before any write.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   in        input      in_valid/in_stall   in_kind, in_start_address,
//                                            in_byte_size
//   out       output     out_valid/out_stall out_status
//   cfg       input      cfg_wr_en           cfg_wr_data (base address)
//
// A transaction runs two decode stages, then a check pass that ends at the
// first failing word and a write pass, both over the memory read port, and
// last loads the result register once the output is free.
// A request rejected in decode skips both passes.
// After reset the memory is cleared one word a cycle through all TABLE_WORDS
// words, and no transaction is accepted until the clear is done.
// A held result does not block acceptance of the next transaction.
// ----------------------------------------------------------------------------
module bitmap_range_mark_erase_unit #(
  parameter int TABLE_WORDS = brme_pkg::TABLE_WORDS_DEFAULT,
  parameter int SLOT_ORDER  = brme_pkg::SLOT_ORDER_DEFAULT,
  parameter int WORD_ORDER  = brme_pkg::WORD_ORDER_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_start_address,
  input  logic [31:0] in_byte_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status
);

  localparam int AW    = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int WBITS = 1 << WORD_ORDER;
  localparam int BW    = WORD_ORDER;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_PASS  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [31:0]      base_r;
  logic             kind_r;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    iss_w_r, iss_w_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_w_r, pend_w_nxt;
  logic             phase_r, phase_nxt;
  logic             status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;

  logic             accept;
  logic             dec_done;
  brme_pkg::brme_range_t range;
  logic [AW-1:0]    sw, ew;
  logic [BW-1:0]    sb, eb;
  logic [BW-1:0]    lo, hi;
  logic [WBITS-1:0] mask;
  logic [WBITS-1:0] rd_data;
  logic             hit_ok;
  logic             out_free;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [WBITS-1:0] mem_wd;

  function automatic logic [WBITS-1:0] span_mask(input logic [BW-1:0] l,
                                                 input logic [BW-1:0] h);
    logic [WBITS-1:0] all_ones;
    logic [BW-1:0]    sh;
    all_ones = '1;
    sh       = BW'(WBITS - 1) - h;
    return (all_ones >> sh) & (all_ones << l);
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  brme_decode #(
    .TABLE_WORDS (TABLE_WORDS),
    .SLOT_ORDER  (SLOT_ORDER),
    .WORD_ORDER  (WORD_ORDER)
  ) u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (accept),
    .start_address (in_start_address),
    .byte_size     (in_byte_size),
    .base_address  (base_r),
    .done          (dec_done),
    .range         (range)
  );

  brme_ram #(
    .DEPTH (TABLE_WORDS),
    .WIDTH (WBITS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (iss_w_r),
    .rd_data (rd_data)
  );

  assign sw = range.first_word[AW-1:0];
  assign ew = range.last_word[AW-1:0];
  assign sb = range.first_bit[BW-1:0];
  assign eb = range.last_bit[BW-1:0];

  always_comb begin
    lo     = (pend_w_r == sw) ? sb : '0;
    hi     = (pend_w_r == ew) ? eb : '1;
    mask   = span_mask(lo, hi);
    hit_ok = (kind_r == brme_pkg::KIND_ERASE) ? ((rd_data & mask) == mask)
                                              : ((rd_data & mask) == '0);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    iss_w_nxt      = iss_w_r;
    iss_done_nxt   = iss_done_r;
    pend_nxt       = pend_r;
    pend_w_nxt     = pend_w_r;
    phase_nxt      = phase_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = pend_w_r;
    mem_wd         = (kind_r == brme_pkg::KIND_ERASE) ? (rd_data & ~mask)
                                                      : (rd_data | mask);

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (dec_done) begin
          if (range.err) begin
            status_nxt = brme_pkg::STATUS_ERROR;
            state_nxt  = S_DONE;
          end else begin
            iss_w_nxt    = sw;
            iss_done_nxt = 1'b0;
            pend_nxt     = 1'b0;
            phase_nxt    = 1'b0;
            state_nxt    = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (!iss_done_r) begin
          pend_nxt     = 1'b1;
          pend_w_nxt   = iss_w_r;
          iss_done_nxt = (iss_w_r == ew);
          iss_w_nxt    = iss_w_r + AW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (!phase_r) begin
            if (!hit_ok) begin
              status_nxt = brme_pkg::STATUS_ERROR;
              state_nxt  = S_DONE;
            end else if (pend_w_r == ew) begin
              phase_nxt    = 1'b1;
              iss_w_nxt    = sw;
              iss_done_nxt = 1'b0;
              pend_nxt     = 1'b0;
            end
          end else begin
            mem_we = 1'b1;
            if (pend_w_r == ew) begin
              status_nxt = brme_pkg::STATUS_DONE;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      iss_done_r  <= 1'b1;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      iss_done_r  <= iss_done_nxt;
      phase_r     <= phase_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
    end
    iss_w_r      <= iss_w_nxt;
    pend_w_r     <= pend_w_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

FILE: src/brme_checker.sv
// ----------------------------------------------------------------------------
// Bitmap range mark/erase port checker
// Concurrent checks on the ports of the unit, attached by bind.
// ----------------------------------------------------------------------------
`include "bitmap_range_mark_erase_unit_defines.svh"

module brme_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_status
);

  `BRME_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, !rst_n, !out_valid && in_stall, "ports active after reset")
  `BRME_ASSERT_NEXT(a_busy_after_accept, clk, !rst_n, in_valid && !in_stall, in_stall, "second transaction taken while one is at work")
  `BRME_ASSERT_NEXT(a_result_hold, clk, !rst_n, out_valid && out_stall, out_valid && $stable(out_status), "stalled result changed")
  `BRME_ASSERT_NEXT(a_no_early_result, clk, !rst_n, in_valid && !in_stall, !$rose(out_valid), "result raised right after acceptance")

endmodule

bind bitmap_range_mark_erase_unit brme_checker u_brme_checker (.*);

FILE: tb/bitmap_range_mark_erase_unit_tb.sv
// ----------------------------------------------------------------------------
// Bitmap range mark/erase unit testbench
// Drives mark and erase requests through the unit under several base
// addresses, idle and stall patterns, predicts each status from a slot-level
// copy of the bitmap, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module bitmap_range_mark_erase_unit_tb;

  localparam int SLOT_SHIFT = brme_pkg::SLOT_ORDER_DEFAULT;
  localparam int SLOT_COUNT = brme_pkg::TABLE_WORDS_DEFAULT << brme_pkg::WORD_ORDER_DEFAULT;
  localparam bit [63:0] SLOT_MASK = (64'd1 << SLOT_SHIFT) - 64'd1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;

  localparam bit [31:0] PHASE_BASE [PHASES] = '{32'h0000_0000, 32'h0004_0000,
    32'h8000_0009, 32'hFFFF_F800, 32'hFFF8_0000, 32'h1234_5670, 32'hFFFF_FFFF,
    32'h0000_0000};
  localparam int PHASE_ITEMS [PHASES] = '{200, 200, 200, 200, 200, 200, 30, 300};
  localparam int SEND_IDLE [4] = '{0, 71, 0, 33};
  localparam int RECV_STALL [4] = '{0, 0, 71, 33};

  class range_ledger;
    bit slot_used [SLOT_COUNT];
    bit [31:0] base;
    logic expected_status [$];
    int unsigned mismatches;

    function void set_base(bit [31:0] value);
      base = value;
    endfunction

    function void note_request(logic kind, bit [31:0] start, bit [31:0] size);
      bit [63:0] first_slot;
      bit [63:0] last_slot;
      bit [63:0] s;
      bit fits;
      logic status;
      status = brme_pkg::STATUS_ERROR;
      if ((start & SLOT_MASK) == 0 && start >= base && size != 0) begin
        first_slot = ({32'd0, start} - base) >> SLOT_SHIFT;
        last_slot = ({32'd0, start} + size - 64'd1 - base) >> SLOT_SHIFT;
        if (last_slot < SLOT_COUNT) begin
          fits = 1'b1;
          for (s = first_slot; s <= last_slot; s++) begin
            if (slot_used[s] != (kind == brme_pkg::KIND_ERASE)) fits = 1'b0;
          end
          if (fits) begin
            for (s = first_slot; s <= last_slot; s++) begin
              slot_used[s] = (kind == brme_pkg::KIND_MARK);
            end
            status = brme_pkg::STATUS_DONE;
          end
        end
      end
      expected_status.push_back(status);
    endfunction

    function void check_result(logic status);
      logic want;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected status transaction: expected none, actual %b",
                 $time, status);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        if (status !== want) begin
          $display("%0t: status mismatch: expected %b, actual %b", $time, want, status);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction
  endclass

  typedef struct {
    int unsigned first;
    bit [31:0] bytes;
  } claim_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = brme_pkg::KIND_MARK;
  logic [31:0] in_start_address = '0;
  logic [31:0] in_byte_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;

  range_ledger ledger = new;
  claim_t claims [$];
  bit [31:0] cur_base;
  int send_idle_pct;
  int recv_stall_pct;
  int unsigned cycles;

  bitmap_range_mark_erase_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_start_address (in_start_address),
    .in_byte_size     (in_byte_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("bitmap_range_mark_erase_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_result(out_status);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(input logic kind, input bit [31:0] start,
                              input bit [31:0] size);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        in_kind <= 1'($urandom_range(1));
        in_start_address <= $urandom;
        in_byte_size <= $urandom;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_start_address <= start;
    in_byte_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(kind, start, size);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input bit [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.set_base(value);
    cur_base = value;
  endtask

  task automatic issue_random_request();
    bit [63:0] abase;
    bit [63:0] reach;
    bit [31:0] start;
    bit [31:0] size;
    bit [31:0] anchor;
    int unsigned region;
    int unsigned slots;
    int unsigned pick;
    int unsigned idx;
    int unsigned dice;
    logic kind;
    claim_t c;
    abase = ({32'd0, cur_base} + SLOT_MASK) & ~SLOT_MASK;
    reach = (abase > 64'hFFFF_FFFF) ? 64'd0 : ((64'hFFFF_FFFF - abase) >> SLOT_SHIFT) + 1;
    region = (reach > 2048) ? 2048 : int'(reach);
    dice = $urandom_range(199);
    if (dice == 0) slots = $urandom_range(SLOT_COUNT, 1);
    else if (dice < 20) slots = $urandom_range(96, 1);
    else slots = $urandom_range(8, 1);
    size = (slots << SLOT_SHIFT) - $urandom_range(int'(SLOT_MASK));
    anchor = (region > 0) ? 32'(abase + ($urandom_range(region - 1) << SLOT_SHIFT))
                          : ($urandom & ~32'(SLOT_MASK));
    kind = 1'($urandom_range(1));
    start = anchor;
    pick = $urandom_range(99);
    if (region == 0 || pick >= 70) begin
      case ($urandom_range(5))
        0: start = anchor | $urandom_range(int'(SLOT_MASK), 1);
        1: begin
          if (cur_base != 0) start = ($urandom % cur_base) & ~32'(SLOT_MASK);
          else start = $urandom;
        end
        2: size = '0;
        3: begin
          if ($urandom_range(1)) size = (SLOT_COUNT << SLOT_SHIFT) + $urandom_range(4095, 1);
          else size = $urandom;
        end
        4: begin
          start = $urandom;
          size = $urandom;
        end
        default: begin
          if (claims.size() > 0) begin
            c = claims[$urandom_range(claims.size() - 1)];
            kind = brme_pkg::KIND_MARK;
            start = 32'(abase + (c.first << SLOT_SHIFT));
            size = c.bytes;
          end else begin
            kind = brme_pkg::KIND_ERASE;
          end
        end
      endcase
    end else if (claims.size() > 0 && (pick < 30 || claims.size() > 150)) begin
      idx = $urandom_range(claims.size() - 1);
      c = claims[idx];
      claims.delete(idx);
      kind = brme_pkg::KIND_ERASE;
      start = 32'(abase + (c.first << SLOT_SHIFT));
      size = c.bytes;
      if ($urandom_range(3) == 0 && c.bytes > (1 << SLOT_SHIFT)) size = c.bytes >> 1;
    end else begin
      c.first = 32'(({32'd0, anchor} - abase) >> SLOT_SHIFT);
      c.bytes = size;
      claims.push_back(c);
      kind = brme_pkg::KIND_MARK;
    end
    send_request(kind, start, size);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_base(32'h0000_0000);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0000, 32'h0000_0001);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0000, 32'h0000_0010);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_0000, 32'h0000_0010);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_0000, 32'h0000_0001);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0008, 32'h0000_0010);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0010, 32'h0000_0000);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_0010, 32'h0000_0000);
    send_request(brme_pkg::KIND_MARK, 32'h0007_FFF0, 32'h0000_0010);
    send_request(brme_pkg::KIND_MARK, 32'h0007_FFF0, 32'h0000_0011);
    send_request(brme_pkg::KIND_MARK, 32'h0008_0000, 32'h0000_0001);
    send_request(brme_pkg::KIND_ERASE, 32'h0007_FFF0, 32'h0000_0010);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0000, 32'h0008_0000);
    send_request(brme_pkg::KIND_MARK, 32'h0000_1000, 32'h0000_0010);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_0000, 32'h0008_0000);
    send_request(brme_pkg::KIND_MARK, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_request(brme_pkg::KIND_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(brme_pkg::KIND_MARK, 32'h0000_01F0, 32'h0000_0020);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_0200, 32'h0000_0010);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_01F0, 32'h0000_0020);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_01F0, 32'h0000_0010);
    wait_for_results();

    write_base(32'h0000_1000);
    send_request(brme_pkg::KIND_MARK, 32'h0000_0FF0, 32'h0000_0010);
    send_request(brme_pkg::KIND_MARK, 32'h0000_1000, 32'h0000_0010);
    send_request(brme_pkg::KIND_ERASE, 32'h0000_1000, 32'h0000_0010);
    wait_for_results();

    for (int p = 0; p < PHASES; p++) begin
      write_base(PHASE_BASE[p]);
      send_idle_pct = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];
      repeat (PHASE_ITEMS[p]) begin
        if ($urandom_range(149) == 0) wait_for_results();
        issue_random_request();
      end
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("bitmap_range_mark_erase_unit test passed");
    end else begin
      $display("bitmap_range_mark_erase_unit test failed");
    end
    $finish;
  end

endmodule
